// ----- rtl/bfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants of the shortest-path core: item codes, result
// kinds, stream word widths and distance limits.
// ----------------------------------------------------------------------------
package bfsp_pkg;

   // request kinds, carried on req_tuser
   typedef enum logic [1:0] {
      OP_ADD_EDGE = 2'd0,
      OP_SOLVE    = 2'd1,
      OP_READ     = 2'd2,
      OP_CLEAR    = 2'd3
   } opcode_type;

   // result kinds, carried on rsp_tuser
   localparam logic KIND_SOLVE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam int VERTEX_FIELD_BITS = 10;
   localparam int WEIGHT_FIELD_BITS = 16;
   localparam int COUNT_REG_BITS    = 11;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int REQ_DATA_BITS     = 48;
   localparam int RSP_DATA_BITS     = 48;
   localparam int DIST_BITS         = 32;
   // one distance word: reach bit above the distance
   localparam int DIST_WORD_BITS    = DIST_BITS + 1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_VERTEX = 1'b1;

   localparam logic [DIST_BITS-1:0] DIST_MAX = 32'h7fff_ffff;
   localparam logic [DIST_BITS-1:0] DIST_MIN = 32'h8000_0000;

endpackage

// ----- rtl/bfsp_ram.sv -----
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bellman_ford_shortest_path_core.sv -----
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_core
// Single-source shortest paths with negative-cycle detection over a stored
// directed edge list, relaxed in place out of block memories.
// ----------------------------------------------------------------------------
// Usage
//   req channel: req_tuser holds the request kind (add edge, solve, read,
//   clear); req_tdata holds edge_from, edge_to, edge_weight and query_vertex.
//   rsp channel: one item for each solve (status) and each read (distance);
//   add and clear items give none.
//   csr port: vertex_count (index 0) and start_vertex (index 1), to be written
//   only while the core is idle; the core itself does not enforce this.
// Timing
//   One item is in work at a time. Add and clear complete when accepted. A
//   read does one distance memory read, then loads the result register. A
//   solve is accepted, sweeps the reach bits of all MAX_VERTICES entries,
//   seeds the start vertex, then runs passes: each pass is a pass check and
//   then, for each edge, one edge-memory read overlapped with one
//   read-modify-write of the distance memories. At most vertex_count passes
//   run; one further pass check flags a negative cycle, then the status loads.
// Reset and stall
//   Reset empties the edge list, clears all flags and sets vertex_count 1,
//   start_vertex 0; vertices read unreachable until the first solve. A
//   result waits in the output register while rsp_tready is low; adds and
//   clears are still taken, a further solve or read is taken and runs, then
//   holds its result and the input until the register drains.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_core #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // slave side
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // edge_from, edge_to, edge_weight, query_vertex, zero fill
   input  logic [bfsp_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   // opcode
   input  logic [1:0]                               req_tuser,
   // master side
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // negative_cycle, edge_overflow, vertex, reachable, distance, zero fill
   output logic [bfsp_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // result_kind
   output logic                                     rsp_tuser,
   // configuration
   input  logic                                     csr_we,
   input  logic [bfsp_pkg::CSR_INDEX_BITS-1:0]      csr_addr,
   input  logic [bfsp_pkg::COUNT_REG_BITS-1:0]      csr_wdata
);

   localparam int VBITS      = bfsp_pkg::VERTEX_FIELD_BITS;
   localparam int VADDR_BITS = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EADDR_BITS = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_BITS  = $clog2(MAX_EDGES + 1);
   localparam int EDGE_BITS  = 2 * VBITS + WEIGHT_BITS;
   localparam int DW         = bfsp_pkg::DIST_WORD_BITS;
   localparam int DB         = bfsp_pkg::DIST_BITS;
   localparam int CB         = bfsp_pkg::COUNT_REG_BITS;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic [VBITS-1:0]       dst;
      logic [VBITS-1:0]       src;
   } edge_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_INIT,
      S_PASS,
      S_EDGE,
      S_RELAX,
      S_RESP
   } state_type;

   // request fields
   bfsp_pkg::opcode_type            req_op;
   logic [VBITS-1:0]                req_from;
   logic [VBITS-1:0]                req_to;
   logic [bfsp_pkg::WEIGHT_FIELD_BITS-1:0] req_weight;
   logic [VBITS-1:0]                req_query;
   logic                            req_fire;

   // state
   state_type                       state_ff, state_in;
   logic [CB-1:0]                   vcount_ff, vcount_in;
   logic [VBITS-1:0]                start_ff, start_in;
   logic [ECNT_BITS-1:0]            total_ff, total_in;
   logic [ECNT_BITS-1:0]            idx_ff, idx_in;
   logic [VADDR_BITS-1:0]           clr_ff, clr_in;
   logic [CB-1:0]                   pass_ff, pass_in;
   logic                            changed_ff, changed_in;
   logic                            overflow_ff, overflow_in;
   logic                            cycle_ff, cycle_in;
   logic                            solved_ff, solved_in;
   logic                            kind_ff, kind_in;
   logic [VBITS-1:0]                query_ff, query_in;
   edge_type                        edge_ff, edge_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bfsp_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_kind_ff, rsp_kind_in;

   // memory ports
   logic                            e_we, e_re;
   logic [EADDR_BITS-1:0]           e_waddr, e_raddr;
   edge_type                        e_wdata, e_rdata;
   logic                            d_we, da_re, db_re;
   logic [VADDR_BITS-1:0]           d_waddr, da_raddr, db_raddr;
   logic [DW-1:0]                   d_wdata, da_rdata, db_rdata;

   // relax datapath
   logic                            src_ok, dst_ok, start_ok, query_ok;
   logic signed [WEIGHT_BITS-1:0]   w_s;
   logic signed [DB+1:0]            sum;
   logic [DB-1:0]                   cand;
   logic                            relax_upd;
   logic                            rsp_free;
   logic [ECNT_BITS-1:0]            idx_next;
   logic [31:0]                     weight_raw;

   assign req_op     = bfsp_pkg::opcode_type'(req_tuser);
   assign req_from   = req_tdata[9:0];
   assign req_to     = req_tdata[19:10];
   assign req_weight = req_tdata[35:20];
   assign req_query  = req_tdata[45:36];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign idx_next   = idx_ff + ECNT_BITS'(1);
   assign weight_raw = 32'(req_weight);

   // vertices outside min(vertex_count, MAX_VERTICES) do not exist
   assign src_ok   = ({1'b0, edge_ff.src} < vcount_ff) && (32'(edge_ff.src) < MAX_VERTICES);
   assign dst_ok   = ({1'b0, edge_ff.dst} < vcount_ff) && (32'(edge_ff.dst) < MAX_VERTICES);
   assign start_ok = ({1'b0, start_ff} < vcount_ff) && (32'(start_ff) < MAX_VERTICES);
   assign query_ok = (32'(query_ff) < MAX_VERTICES);

   // saturating candidate distance
   always_comb begin
      w_s  = edge_ff.weight;
      sum  = (DB + 2)'(signed'(da_rdata[DB-1:0])) + (DB + 2)'(w_s);
      if ((sum[DB+1] != sum[DB-1]) || (sum[DB] != sum[DB-1])) begin
         cand = sum[DB+1] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
      end else begin
         cand = sum[DB-1:0];
      end
      relax_upd = src_ok && dst_ok && da_rdata[DB]
                  && (!db_rdata[DB] || (signed'(cand) < signed'(db_rdata[DB-1:0])));
   end

   // memory control
   always_comb begin
      e_we     = 1'b0;
      e_waddr  = total_ff[EADDR_BITS-1:0];
      e_wdata  = '{weight: weight_raw[WEIGHT_BITS-1:0], dst: req_to, src: req_from};
      e_re     = 1'b0;
      e_raddr  = idx_next[EADDR_BITS-1:0];
      d_we     = 1'b0;
      d_waddr  = VADDR_BITS'(edge_ff.dst);
      d_wdata  = {1'b1, cand};
      da_re    = 1'b0;
      da_raddr = VADDR_BITS'(e_rdata.src);
      db_re    = 1'b0;
      db_raddr = VADDR_BITS'(e_rdata.dst);
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_op == bfsp_pkg::OP_ADD_EDGE)
                && (32'(total_ff) < MAX_EDGES)) begin
               e_we = 1'b1;
            end
            if (req_fire && (req_op == bfsp_pkg::OP_READ)) begin
               da_re    = 1'b1;
               da_raddr = VADDR_BITS'(req_query);
            end
         end
         S_CLEAR: begin
            d_we    = 1'b1;
            d_waddr = clr_ff;
            d_wdata = '0;
         end
         S_INIT: begin
            d_we    = start_ok;
            d_waddr = VADDR_BITS'(start_ff);
            d_wdata = {1'b1, {DB{1'b0}}};
         end
         S_PASS: begin
            e_re    = (pass_ff < vcount_ff) && (total_ff != '0);
            e_raddr = '0;
         end
         S_EDGE: begin
            // edge data is for idx_ff; prefetch the next edge
            da_re = 1'b1;
            db_re = 1'b1;
            e_re  = 1'b1;
         end
         S_RELAX: begin
            d_we = relax_upd;
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      start_in     = start_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      pass_in      = pass_ff;
      changed_in   = changed_ff;
      overflow_in  = overflow_ff;
      cycle_in     = cycle_ff;
      solved_in    = solved_ff;
      kind_in      = kind_ff;
      query_in     = query_ff;
      edge_in      = edge_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;

      if (csr_we) begin
         unique case (csr_addr)
            bfsp_pkg::CSR_VERTEX_COUNT: vcount_in = csr_wdata;
            bfsp_pkg::CSR_START_VERTEX: start_in  = csr_wdata[VBITS-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  bfsp_pkg::OP_ADD_EDGE: begin
                     if (32'(total_ff) < MAX_EDGES) begin
                        total_in = total_ff + ECNT_BITS'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  bfsp_pkg::OP_CLEAR: begin
                     total_in    = '0;
                     overflow_in = 1'b0;
                  end
                  bfsp_pkg::OP_SOLVE: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  bfsp_pkg::OP_READ: begin
                     query_in = req_query;
                     kind_in  = bfsp_pkg::KIND_READ;
                     state_in = S_RESP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLEAR: begin
            clr_in = clr_ff + VADDR_BITS'(1);
            if (clr_ff == VADDR_BITS'(MAX_VERTICES - 1)) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            solved_in  = 1'b1;
            cycle_in   = 1'b0;
            pass_in    = '0;
            changed_in = 1'b1;
            kind_in    = bfsp_pkg::KIND_SOLVE;
            state_in   = S_PASS;
         end
         S_PASS: begin
            if (pass_ff >= vcount_ff) begin
               // one pass more than vertices allow
               cycle_in = 1'b1;
               state_in = S_RESP;
            end else begin
               pass_in    = pass_ff + CB'(1);
               changed_in = 1'b0;
               idx_in     = '0;
               state_in   = (total_ff == '0) ? S_RESP : S_EDGE;
            end
         end
         S_EDGE: begin
            edge_in  = e_rdata;
            idx_in   = idx_next;
            state_in = S_RELAX;
         end
         S_RELAX: begin
            changed_in = changed_ff || relax_upd;
            if (idx_ff == total_ff) begin
               state_in = (changed_ff || relax_upd) ? S_PASS : S_RESP;
            end else begin
               state_in = S_EDGE;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_data_in  = '0;
               rsp_data_in[0] = cycle_ff;
               rsp_data_in[1] = overflow_ff;
               if (kind_ff == bfsp_pkg::KIND_READ) begin
                  rsp_data_in[11:2] = query_ff;
                  if (solved_ff && query_ok && da_rdata[DB]) begin
                     rsp_data_in[12]    = 1'b1;
                     rsp_data_in[44:13] = da_rdata[DB-1:0];
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= CB'(1);
         start_ff     <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         clr_ff       <= '0;
         pass_ff      <= '0;
         changed_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         cycle_ff     <= 1'b0;
         solved_ff    <= 1'b0;
         kind_ff      <= bfsp_pkg::KIND_SOLVE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         start_ff     <= start_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         clr_ff       <= clr_in;
         pass_ff      <= pass_in;
         changed_ff   <= changed_in;
         overflow_ff  <= overflow_in;
         cycle_ff     <= cycle_in;
         solved_ff    <= solved_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff    <= query_in;
      edge_ff     <= edge_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   bfsp_ram #(
      .WIDTH (EDGE_BITS),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_en   (e_re),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   // two copies of the distance store give the source and destination reads
   bfsp_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_VERTICES)
   ) u_dist_src_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_en   (da_re),
      .rd_addr (da_raddr),
      .rd_data (da_rdata)
   );

   bfsp_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_VERTICES)
   ) u_dist_dst_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_en   (db_re),
      .rd_addr (db_raddr),
      .rd_data (db_rdata)
   );

`ifndef SYNTHESIS
   a_total_bound : assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= MAX_EDGES)
      else $error("edge count beyond capacity");

   a_pass_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RELAX) |-> (pass_ff <= vcount_ff) && (pass_ff != '0))
      else $error("relaxing outside the pass limit");

   a_solve_sweep : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == bfsp_pkg::OP_SOLVE)) |=> (state_ff == S_CLEAR) && (clr_ff == '0))
      else $error("solve did not start the reach sweep");

   a_dist_write : assert property (@(posedge clock) disable iff (reset)
      d_we |-> (state_ff == S_CLEAR) || (state_ff == S_INIT) || (state_ff == S_RELAX))
      else $error("distance write outside a solve");

   a_solve_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == bfsp_pkg::KIND_SOLVE)) |-> (rsp_data_ff[44:2] == '0))
      else $error("solve status carries read fields");
`endif

endmodule

// ----- verif/bellman_ford_shortest_path_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_core_tb
// Drives add-edge, clear, solve and read items into the shortest-path core.
// A predictor in the bench keeps its own edge list and distance table and
// works out every solve status and read answer. The checker compares each
// result field by field. Both stream sides idle at random, and one long
// output stall fills the core up.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_core_tb;

   localparam int MAX_V         = 1024;
   localparam int MAX_E         = 4096;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int LONG_HOLD     = 2000;
   localparam int IDLE_LIMIT    = 1000000;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      logic              kind;
      logic              neg_cycle;
      logic              overflow;
      logic [9:0]        vertex;
      logic              reachable;
      logic signed [31:0] distance;
   } path_answer_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [bfsp_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [bfsp_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we;
   logic [bfsp_pkg::CSR_INDEX_BITS-1:0] csr_addr;
   logic [bfsp_pkg::COUNT_REG_BITS-1:0] csr_wdata;

   // predictor state
   logic [9:0]         edge_src_m [MAX_E];
   logic [9:0]         edge_dst_m [MAX_E];
   logic signed [15:0] edge_w_m   [MAX_E];
   int unsigned        edge_count;
   logic signed [31:0] dist_m  [MAX_V];
   bit                 reach_m [MAX_V];
   bit                 overflow_seen;
   bit                 cycle_seen;
   logic [10:0]        cfg_vertex_count;
   logic [9:0]         cfg_start;

   path_answer_type expected_answers[$];

   int  fail_count;
   int  items_sent;
   int  results_checked;
   int  cycle_reports;
   int  overflow_reports;
   bit  no_idle;
   int  long_holds_asked;
   int  long_holds_done;
   int  idle_cycles;

   bellman_ford_shortest_path_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic logic signed [31:0] clamp_sum(logic signed [31:0] a,
                                                    logic signed [15:0] w);
      longint s;
      s = longint'(a) + longint'(w);
      if (s < -64'sd2147483648) return 32'sh8000_0000;
      if (s > 64'sd2147483647) return 32'sh7fff_ffff;
      return s[31:0];
   endfunction

   function automatic void compute_shortest_paths();
      int unsigned lim;
      int unsigned passes;
      bit changed;
      int unsigned u;
      int unsigned v;
      logic signed [31:0] cand;
      lim = (cfg_vertex_count < MAX_V) ? cfg_vertex_count : MAX_V;
      for (int i = 0; i < MAX_V; i++) reach_m[i] = 1'b0;
      if (cfg_start < lim) begin
         reach_m[cfg_start] = 1'b1;
         dist_m[cfg_start] = 0;
      end
      cycle_seen = 1'b0;
      passes = 0;
      changed = 1'b1;
      while (changed) begin
         passes++;
         if (passes > cfg_vertex_count) begin
            cycle_seen = 1'b1;
            return;
         end
         changed = 1'b0;
         for (int e = 0; e < edge_count; e++) begin
            u = edge_src_m[e];
            v = edge_dst_m[e];
            if (u < lim && v < lim && reach_m[u]) begin
               cand = clamp_sum(dist_m[u], edge_w_m[e]);
               if (!reach_m[v] || cand < dist_m[v]) begin
                  dist_m[v] = cand;
                  reach_m[v] = 1'b1;
                  changed = 1'b1;
               end
            end
         end
      end
   endfunction

   function automatic void apply_request(bfsp_pkg::opcode_type op, logic [9:0] from_v,
                                         logic [9:0] to_v, logic [15:0] weight,
                                         logic [9:0] query);
      path_answer_type ans;
      case (op)
         bfsp_pkg::OP_ADD_EDGE: begin
            if (edge_count < MAX_E) begin
               edge_src_m[edge_count] = from_v;
               edge_dst_m[edge_count] = to_v;
               edge_w_m[edge_count]   = weight;
               edge_count++;
            end else begin
               overflow_seen = 1'b1;
            end
         end
         bfsp_pkg::OP_CLEAR: begin
            edge_count = 0;
            overflow_seen = 1'b0;
         end
         bfsp_pkg::OP_SOLVE: begin
            compute_shortest_paths();
            ans.kind      = bfsp_pkg::KIND_SOLVE;
            ans.neg_cycle = cycle_seen;
            ans.overflow  = overflow_seen;
            ans.vertex    = '0;
            ans.reachable = 1'b0;
            ans.distance  = '0;
            expected_answers.push_back(ans);
         end
         default: begin
            ans.kind      = bfsp_pkg::KIND_READ;
            ans.neg_cycle = cycle_seen;
            ans.overflow  = overflow_seen;
            ans.vertex    = query;
            ans.reachable = reach_m[query];
            ans.distance  = reach_m[query] ? dist_m[query] : 32'sd0;
            expected_answers.push_back(ans);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic send_item(bfsp_pkg::opcode_type op, logic [9:0] from_v,
                            logic [9:0] to_v, logic [15:0] weight, logic [9:0] query);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, query, weight, to_v, from_v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(op, from_v, to_v, weight, query);
      items_sent++;
   endtask

   task automatic add_edge(logic [9:0] from_v, logic [9:0] to_v, logic [15:0] weight);
      send_item(bfsp_pkg::OP_ADD_EDGE, from_v, to_v, weight, 10'($urandom));
   endtask

   task automatic read_vertex(logic [9:0] query);
      send_item(bfsp_pkg::OP_READ, 10'($urandom), 10'($urandom), 16'($urandom), query);
   endtask

   task automatic send_solve();
      send_item(bfsp_pkg::OP_SOLVE, 10'($urandom), 10'($urandom), 16'($urandom),
                10'($urandom));
   endtask

   task automatic send_clear();
      send_item(bfsp_pkg::OP_CLEAR, 10'($urandom), 10'($urandom), 16'($urandom),
                10'($urandom));
   endtask

   // wait until every result is in, then let a trailing add or clear finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setup(logic [10:0] count, logic [9:0] start);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= bfsp_pkg::CSR_VERTEX_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      cfg_vertex_count = count;
      csr_addr  <= bfsp_pkg::CSR_START_VERTEX;
      csr_wdata <= {1'b0, start};
      @(posedge clock);
      cfg_start = start;
      csr_we <= 1'b0;
   endtask

   function automatic logic [9:0] pick_vertex();
      int unsigned lim;
      int unsigned r;
      lim = (cfg_vertex_count < MAX_V) ? cfg_vertex_count : MAX_V;
      r = $urandom_range(0, 99);
      if (lim == 0 || r < 10) return 10'($urandom);
      if (r < 30) return cfg_start;
      if (r < 75) return 10'($urandom_range(0, ((lim < 16) ? lim : 16) - 1));
      return 10'($urandom_range(0, lim - 1));
   endfunction

   function automatic logic [15:0] pick_weight(bit nonneg);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (nonneg) return 16'($urandom_range(0, 32767));
      if (r < 70) return 16'($urandom_range(0, 100));
      if (r < 90) return 16'(-$urandom_range(1, 20));
      return 16'($urandom);
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_power_on_state();
      read_vertex(10'd0);
      read_vertex(10'd1023);
      send_solve();
      read_vertex(10'd0);
   endtask

   task automatic test_directed_graphs();
      write_setup(11'd8, 10'd0);
      add_edge(10'd0, 10'd1, 16'd5);
      add_edge(10'd1, 10'd2, -16'sd3);
      add_edge(10'd0, 10'd2, 16'sh7fff);
      add_edge(10'd2, 10'd3, 16'sh8000);
      add_edge(10'd1023, 10'd4, 16'd1);   // source does not exist
      add_edge(10'd4, 10'd1023, 16'd1);
      add_edge(10'd3, 10'd7, 16'd0);
      send_solve();
      read_vertex(10'd2);
      read_vertex(10'd3);
      read_vertex(10'd7);
      read_vertex(10'd4);
      read_vertex(10'd1023);
      // start outside the vertex range
      write_setup(11'd8, 10'd9);
      send_solve();
      read_vertex(10'd0);
      // no vertices at all: flagged as a cycle on the first pass
      write_setup(11'd0, 10'd0);
      send_solve();
      read_vertex(10'd0);
      // two-vertex negative loop
      send_clear();
      write_setup(11'd3, 10'd0);
      add_edge(10'd0, 10'd1, -16'sd1);
      add_edge(10'd1, 10'd0, -16'sd1);
      send_solve();
      read_vertex(10'd1);
      read_vertex(10'd0);
   endtask

   task automatic test_distance_saturation();
      send_clear();
      write_setup(11'd1024, 10'd5);
      add_edge(10'd5, 10'd7, 16'sh7fff);
      // many copies of a heavy negative self loop drive vertex 5 to the floor
      repeat (80) add_edge(10'd5, 10'd5, 16'sh8000);
      send_solve();
      read_vertex(10'd5);
      read_vertex(10'd7);
   endtask

   task automatic test_edge_overflow();
      send_clear();
      write_setup(11'd4, 10'd0);
      repeat (MAX_E) add_edge(10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)),
                              16'($urandom));
      repeat (3) add_edge(10'd0, 10'd1, 16'd1);
      send_solve();
      read_vertex(10'd1);
      send_clear();
      send_solve();
      read_vertex(10'd0);
   endtask

   task automatic test_output_backpressure();
      send_clear();
      write_setup(11'd6, 10'd0);
      add_edge(10'd0, 10'd1, 16'd3);
      add_edge(10'd1, 10'd2, 16'd4);
      wait_idle();
      long_holds_asked++;
      @(posedge clock);
      read_vertex(10'd2);
      add_edge(10'd2, 10'd3, 16'd1);
      add_edge(10'd3, 10'd4, 16'd1);
      send_solve();
      read_vertex(10'd4);
      read_vertex(10'd5);
      add_edge(10'd4, 10'd5, 16'd2);
      send_solve();
      read_vertex(10'd5);
   endtask

   task automatic run_random_sequence(bit nonneg);
      int n_edges;
      n_edges = $urandom_range(1, 20);
      if (edge_count > 60 || $urandom_range(0, 3) != 0) send_clear();
      if ($urandom_range(0, 5) == 0) read_vertex(pick_vertex());
      repeat (n_edges) begin
         if ($urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 1) == 0) read_vertex(10'($urandom));
            else send_clear();
         end
         add_edge(pick_vertex(), pick_vertex(), pick_weight(nonneg));
      end
      send_solve();
      repeat ($urandom_range(2, 8)) read_vertex(pick_vertex());
   endtask

   task automatic test_random_traffic();
      int base;
      int phase;
      bit nonneg;
      logic [10:0] count;
      logic [9:0] start;
      base = items_sent;
      phase = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         nonneg = 1'b0;
         case (phase)
            0: begin count = 11'd1024; start = 10'd1023; nonneg = 1'b1; end
            1: begin count = 11'd1;    start = 10'd0; end
            2: begin count = 11'd2;    start = 10'd1; end
            3: begin count = 11'd1024; start = 10'd0;   nonneg = 1'b1; end
            default: begin
               count  = 11'($urandom_range(1, 32));
               start  = 10'($urandom_range(0, count));
               nonneg = ($urandom_range(0, 3) == 0);
            end
         endcase
         write_setup(count, start);
         repeat (6) begin
            run_random_sequence(nonneg);
            // last stretch runs flat out on both sides
            if (items_sent - base > RANDOM_ITEMS * 4 / 5) no_idle = 1'b1;
         end
         phase++;
      end
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   initial begin : rsp_ready_drive
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_holds_done < long_holds_asked) begin
            long_holds_done++;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      path_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            $error("result with nothing expected: tuser %0b tdata %h", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_answers.pop_front();
            results_checked++;
            if (want.kind == bfsp_pkg::KIND_SOLVE && want.neg_cycle) cycle_reports++;
            if (want.kind == bfsp_pkg::KIND_SOLVE && want.overflow) overflow_reports++;
            if (rsp_tuser !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[0] !== want.neg_cycle) begin
               $error("negative_cycle: expected %0d, got %0d", want.neg_cycle, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[1] !== want.overflow) begin
               $error("edge_overflow: expected %0d, got %0d", want.overflow, rsp_tdata[1]);
               fail_count++;
            end
            if (rsp_tdata[11:2] !== want.vertex) begin
               $error("vertex: expected %0d, got %0d", want.vertex, rsp_tdata[11:2]);
               fail_count++;
            end
            if (rsp_tdata[12] !== want.reachable) begin
               $error("reachable: expected %0d, got %0d", want.reachable, rsp_tdata[12]);
               fail_count++;
            end
            if (rsp_tdata[44:13] !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance,
                      $signed(rsp_tdata[44:13]));
               fail_count++;
            end
         end
      end
   end

   // no item moving on either side for too long means the core has hung
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item accepted for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = bfsp_pkg::OP_ADD_EDGE;
      csr_we     = 1'b0;
      csr_addr   = bfsp_pkg::CSR_VERTEX_COUNT;
      csr_wdata  = '0;
      idle_cycles = 0;
      fail_count = 0;
      items_sent = 0;
      results_checked = 0;
      cycle_reports = 0;
      overflow_reports = 0;
      no_idle = 1'b0;
      long_holds_asked = 0;
      long_holds_done = 0;
      edge_count = 0;
      overflow_seen = 1'b0;
      cycle_seen = 1'b0;
      cfg_vertex_count = 11'd1;
      cfg_start = 10'd0;
      for (int i = 0; i < MAX_V; i++) reach_m[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on_state();
      test_directed_graphs();
      test_distance_saturation();
      test_edge_overflow();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d items and %0d results, %0d solves hit a negative cycle,",
               items_sent, results_checked, cycle_reports);
      $display("%0d solves reported dropped edges, with one long output stall",
               overflow_reports);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- bellman_ford_shortest_path_core.f -----
rtl/bfsp_pkg.sv
rtl/bfsp_ram.sv
rtl/bellman_ford_shortest_path_core.sv
verif/bellman_ford_shortest_path_core_tb.sv
